/* rtl/core/histogram_inversion_counter_top_defines.svh */
// Assertion macros for the verification checker of the inversion counter.
// Depends on nothing; included by the checker module.
`ifndef HISTOGRAM_INVERSION_COUNTER_TOP_DEFINES_SVH
`define HISTOGRAM_INVERSION_COUNTER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HIC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HIC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/hic_pkg.sv */
// Shared widths and limits of the histogram inversion counter.
// No dependencies; imported by the top level and its checker.
`timescale 1ns / 1ps
`default_nettype none

package hic_pkg;

	localparam int VALUE_RANGE = 16;
	localparam int VALUE_W     = 4;
	localparam int BIN_W       = 11;
	localparam int TOTAL_W     = 20;
	localparam int IDX_W       = $clog2(VALUE_RANGE);
	localparam int SUM_W       = BIN_W + IDX_W;

	localparam logic [BIN_W-1:0]   BIN_MAX   = {BIN_W{1'b1}};
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
	localparam logic [IDX_W-1:0]   IDX_TOP   = IDX_W'(VALUE_RANGE - 1);

endpackage

`default_nettype wire

/* rtl/core/histogram_inversion_counter_top.sv */
// Top level of the histogram inversion counter: bin memory, walk sequencer and result register.
// Depends on hic_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake            Payload
// input     in_valid/in_ready    value, last_item
// output    out_valid/out_ready  inversion_total, sequence_done
//
// After an item's transfer, the sequencer reads the bins 0 to v from the bin memory at one
// read a cycle, where v is the clamped value, so the bin walk over the memory read port sets
// how long the item takes until its result is loaded. The next transfer can follow in the
// cycle after the load, so the block takes no new item before the last one's result is loaded.
// The reset is asynchronous and clears the bin valid bits, so no clearing pass is needed and
// the block accepts an item as soon as reset is released. A stalled result sits in the
// output register while the next item is taken and walked; the sequencer only waits if it
// finishes before that result has been transferred.

module histogram_inversion_counter_top (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [hic_pkg::VALUE_W-1:0]  value,
	input  wire logic                         last_item,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [hic_pkg::TOTAL_W-1:0]       inversion_total,
	output logic                              sequence_done
);

	import hic_pkg::*;

	// One-hot sequencer states.
	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_WALK   = 4'b0010,
		S_UPDATE = 4'b0100,
		S_OUT    = 4'b1000
	} state_t;

	state_t state_q, state_d;

	// Bin memory. Its contents are never reset; instead each entry has a valid bit, and an
	// entry whose bit is clear reads as zero. Clearing all valid bits at once empties the
	// histogram, both at reset and at the end of a sequence.
	logic [BIN_W-1:0]       bin_mem [VALUE_RANGE];
	logic [VALUE_RANGE-1:0] entry_valid_q;

	logic [IDX_W-1:0]   v_q;          // clamped value of the item being worked on
	logic               last_q;       // sequence end mark of that item
	logic [IDX_W-1:0]   k_q;          // address of the bin being read
	logic [SUM_W-1:0]   below_q;      // sum of the bins below v_q
	logic [TOTAL_W-1:0] total_q;      // running inversion total

	// Read stage: data returned by the memory in the cycle after its address.
	logic [BIN_W-1:0]   rd_data_s1;
	logic               rd_vld_s1;    // entry had been written since the last clear
	logic               rd_busy_s1;   // a walk read was issued in the previous cycle

	logic [IDX_W-1:0]   v_clamped;
	logic [BIN_W-1:0]   bin_cur;
	logic [BIN_W-1:0]   bin_next;
	logic [TOTAL_W:0]   total_sum;
	logic [TOTAL_W-1:0] total_next;
	logic               accept;
	logic               out_load;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_load = (state_q == S_OUT) && (!out_valid || out_ready);

	// Values beyond the histogram are counted in its topmost bin.
	always_comb begin
		if (int'(value) >= VALUE_RANGE) begin
			v_clamped = IDX_TOP;
		end else begin
			v_clamped = IDX_W'(value);
		end
	end

	assign bin_cur  = rd_vld_s1 ? rd_data_s1 : '0;
	assign bin_next = (bin_cur == BIN_MAX) ? BIN_MAX : bin_cur + 1'b1;

	// Saturating add of the bins below onto the running total.
	assign total_sum  = {1'b0, total_q} + (TOTAL_W + 1)'(below_q);
	assign total_next = total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_WALK;
				end
			end
			S_WALK: begin
				if (k_q == v_q) begin
					state_d = S_UPDATE;
				end
			end
			S_UPDATE: begin
				state_d = S_OUT;
			end
			S_OUT: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Memory read port: the walk reads one bin a cycle, from bin 0 up to the item's own bin.
	always_ff @(posedge clk) begin
		rd_data_s1 <= bin_mem[k_q];
	end

	// Memory write port: the item's own bin, incremented with saturation, is written back in
	// the update cycle. The next read of any bin belongs to a later item, which cannot start
	// before this write, so no forwarding is needed.
	always_ff @(posedge clk) begin
		if (state_q == S_UPDATE) begin
			bin_mem[v_q] <= bin_next;
		end
	end

	// Item registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			v_q    <= v_clamped;
			last_q <= last_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q        <= '0;
			below_q    <= '0;
			rd_busy_s1 <= 1'b0;
			rd_vld_s1  <= 1'b0;
		end else begin
			rd_busy_s1 <= (state_q == S_WALK);
			rd_vld_s1  <= entry_valid_q[k_q];
			if (accept) begin
				k_q     <= '0;
				below_q <= '0;
			end else begin
				if ((state_q == S_WALK) && (k_q != v_q)) begin
					k_q <= k_q + 1'b1;
				end
				// While walking, the returned data belongs to a bin below the item's own.
				if (rd_busy_s1 && (state_q == S_WALK)) begin
					below_q <= below_q + SUM_W'(bin_cur);
				end
			end
		end
	end

	// Running total and valid bits. The end of a sequence clears both once its result has
	// been loaded into the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q       <= '0;
			entry_valid_q <= '0;
		end else begin
			if (state_q == S_UPDATE) begin
				total_q          <= total_next;
				entry_valid_q[v_q] <= 1'b1;
			end else if (out_load && last_q) begin
				total_q       <= '0;
				entry_valid_q <= '0;
			end
		end
	end

	// Output register, which parts the result from the sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			inversion_total <= total_q;
			sequence_done   <= last_q;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/hic_checker.sv */
// Port-level checker of the histogram inversion counter, bound to the top level.
// Depends on hic_pkg and histogram_inversion_counter_top_defines.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "histogram_inversion_counter_top_defines.svh"

module hic_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        in_valid,
	input wire logic                        in_ready,
	input wire logic [hic_pkg::VALUE_W-1:0] value,
	input wire logic                        last_item,
	input wire logic                        out_valid,
	input wire logic                        out_ready,
	input wire logic [hic_pkg::TOTAL_W-1:0] inversion_total,
	input wire logic                        sequence_done
);

	import hic_pkg::*;

	logic in_xfer;
	logic out_hold;

	assign in_xfer  = in_valid && in_ready && (value == value) && (last_item == last_item);
	assign out_hold = out_valid && !out_ready;

	// A stalled result keeps its payload.
	`HIC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_hold, out_valid && $stable(inversion_total) && $stable(sequence_done), "result changed while stalled")

	// One item at a time: after a transfer in, the input is closed.
	`HIC_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, in_xfer, !in_ready, "input reopened straight after a transfer")

	// A new result appears exactly as the sequencer returns to idle.
	`HIC_ASSERT_SAME(a_result_reopens, clk, arst_n, $rose(out_valid), in_ready, "result loaded while still busy")

	// The total never exceeds its saturation limit.
	`HIC_ASSERT_SAME(a_total_limit, clk, arst_n, out_valid, inversion_total <= TOTAL_MAX, "total beyond its limit")

endmodule

bind histogram_inversion_counter_top hic_checker u_hic_checker (.*);

`default_nettype wire

/* bench/histogram_inversion_counter_top_tb.sv */
// Self-checking testbench for the histogram inversion counter: directed rows, a full-length
// sequence and random sequences under varying idle and stall patterns.
// Depends on hic_pkg and histogram_inversion_counter_top.
`timescale 1ns / 1ps

module histogram_inversion_counter_top_tb;

	import hic_pkg::*;

	// One expected result: the running total and the end-of-sequence flag.
	typedef struct packed {
		logic [TOTAL_W-1:0] total;
		logic               done;
	} tally_t;

	// A directed stimulus row. Where known is set, the total is typed in and checked as it
	// stands; otherwise the expectation comes from the predictor.
	typedef struct packed {
		logic [VALUE_W-1:0] val;
		logic               last;
		logic               known;
		logic [TOTAL_W-1:0] total;
	} directed_row_t;

	localparam int N_DIRECTED = 17;

	// The sequence is presented last element first, so a value arriving after a smaller one
	// counts as an inversion against it.
	localparam directed_row_t DIRECTED_ROWS [N_DIRECTED] = '{
		'{4'd0,  1'b1, 1'b1, 20'd0},	// single element straight after reset
		'{4'd15, 1'b1, 1'b1, 20'd0},	// single largest element
		'{4'd0,  1'b0, 1'b1, 20'd0},
		'{4'd15, 1'b1, 1'b1, 20'd1},	// one inversion between the two extremes
		'{4'd0,  1'b0, 1'b1, 20'd0},
		'{4'd5,  1'b0, 1'b1, 20'd1},
		'{4'd10, 1'b0, 1'b1, 20'd3},
		'{4'd15, 1'b1, 1'b1, 20'd6},
		'{4'd15, 1'b0, 1'b1, 20'd0},	// equal values never count
		'{4'd15, 1'b0, 1'b1, 20'd0},
		'{4'd0,  1'b1, 1'b1, 20'd0},
		'{4'd7,  1'b0, 1'b0, 20'd0},
		'{4'd3,  1'b0, 1'b0, 20'd0},
		'{4'd7,  1'b0, 1'b0, 20'd0},
		'{4'd12, 1'b0, 1'b0, 20'd0},
		'{4'd1,  1'b0, 1'b0, 20'd0},
		'{4'd8,  1'b1, 1'b0, 20'd0}
	};

	// Full-length sequence: sixteen ascending groups of equal size.
	localparam int                 LONG_GROUP = 64;
	localparam logic [TOTAL_W-1:0] LONG_TOTAL = 20'd491520;	// 64 * 64 * (0 + 1 + ... + 15)

	localparam int RANDOM_PER_PHASE = 120;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [VALUE_W-1:0] value = '0;
	logic               last_item = 1'b0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [TOTAL_W-1:0] inversion_total;
	logic               sequence_done;

	// Predictor state: one occurrence count per value and the running inversion total.
	logic [BIN_W-1:0]   bin_count [VALUE_RANGE];
	logic [TOTAL_W-1:0] run_total;

	tally_t pending_tallies [$];
	int     fail_count = 0;
	int     send_idle_pct = 0;
	int     recv_stall_pct = 0;
	int     hold_off_left = 0;

	histogram_inversion_counter_top dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.value           (value),
		.last_item       (last_item),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.inversion_total (inversion_total),
		.sequence_done   (sequence_done)
	);

	initial begin
		forever begin
			#5 clk = ~clk;
		end
	end

	// Timeout: the slowest legal run is well under a tenth of this.
	initial begin
		#10_000_000;
		$display("histogram_inversion_counter_top_tb: FAIL");
		$finish;
	end

	task automatic flag_mismatch(input string msg);
		$display("%0t ns: %s", $time, msg);
		fail_count++;
	endtask

	function automatic void clear_histogram();
		for (int k = 0; k < VALUE_RANGE; k++) begin
			bin_count[k] = '0;
		end
		run_total = '0;
	endfunction

	// Counts one element into its bin and adds every smaller element seen so far to the
	// total. Both the bins and the total stick at their maxima. A last element returns the
	// final count and leaves the histogram clear for the next sequence.
	function automatic logic [TOTAL_W-1:0] advance_tally(input logic [VALUE_W-1:0] v_in,
			input logic last);
		int unsigned idx;
		int unsigned smaller;
		logic [TOTAL_W-1:0] result;
		idx = (v_in >= VALUE_RANGE) ? VALUE_RANGE - 1 : v_in;
		if (bin_count[idx] != BIN_MAX) begin
			bin_count[idx] = bin_count[idx] + 1'b1;
		end
		smaller = 0;
		for (int k = 0; k < idx; k++) begin
			smaller += bin_count[k];
		end
		if (smaller >= TOTAL_MAX - run_total) begin
			run_total = TOTAL_MAX;
		end else begin
			run_total = run_total + TOTAL_W'(smaller);
		end
		result = run_total;
		if (last) begin
			clear_histogram();
		end
		return result;
	endfunction

	// Offers one item, holding it until its transfer, then queues what it should produce.
	// Idle cycles are inserted before the offer at the current sender rate.
	task automatic send_item(input logic [VALUE_W-1:0] v, input logic last,
			input logic known, input logic [TOTAL_W-1:0] typed_total);
		logic [TOTAL_W-1:0] predicted;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		value     <= v;
		last_item <= last;
		do begin
			@(posedge clk);
		end while (!in_ready);
		predicted = advance_tally(v, last);
		pending_tallies.push_back('{total: known ? typed_total : predicted, done: last});
	endtask

	// A sequence of random length and content. Most are short; the value window is often
	// narrowed so that repeats and equal values are common, and a few items ignore it.
	task automatic send_random_sequence(inout int sent);
		int unsigned len;
		int unsigned lo;
		int unsigned hi;
		int unsigned pick;
		logic [VALUE_W-1:0] v;
		pick = $urandom_range(99);
		if (pick < 70) begin
			len = $urandom_range(12, 1);
		end else if (pick < 95) begin
			len = $urandom_range(60, 13);
		end else begin
			len = $urandom_range(200, 61);
		end
		hi = ($urandom_range(1) != 0) ? VALUE_RANGE - 1 : $urandom_range(VALUE_RANGE - 1, 1);
		lo = ($urandom_range(1) != 0) ? 0 : $urandom_range(hi, 0);
		for (int unsigned n = 0; n < len; n++) begin
			if ($urandom_range(9) == 0) begin
				v = VALUE_W'($urandom_range(VALUE_RANGE - 1, 0));
			end else begin
				v = VALUE_W'($urandom_range(hi, lo));
			end
			send_item(v, n == len - 1, 1'b0, '0);
			sent++;
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_tallies.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// Result side: checks each transfer against the oldest expectation and decides the next
	// cycle's ready. A requested hold-off keeps ready low for that many cycles so that the
	// block fills up and pushes back on its input.
	always @(posedge clk) begin
		tally_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_tallies.size() == 0) begin
					flag_mismatch($sformatf("unexpected result total=%0d done=%0b",
						inversion_total, sequence_done));
				end else begin
					want = pending_tallies.pop_front();
					if (inversion_total !== want.total) begin
						flag_mismatch($sformatf("inversion_total %0d, expected %0d",
							inversion_total, want.total));
					end
					if (sequence_done !== want.done) begin
						flag_mismatch($sformatf("sequence_done %0b, expected %0b",
							sequence_done, want.done));
					end
				end
			end
			if (hold_off_left > 0) begin
				hold_off_left = hold_off_left - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	initial begin
		int sent;
		clear_histogram();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows, with neither side idling.
		for (int r = 0; r < N_DIRECTED; r++) begin
			send_item(DIRECTED_ROWS[r].val, DIRECTED_ROWS[r].last, DIRECTED_ROWS[r].known,
				DIRECTED_ROWS[r].total);
		end

		// A long sequence in sixteen equal ascending groups, starting with
		// value zero. Every element of a group sees all the smaller groups before it, which
		// gives the largest total such a sequence can reach. Only the final total is typed
		// in; the rest follow the predictor.
		for (int g = 0; g < VALUE_RANGE; g++) begin
			for (int n = 0; n < LONG_GROUP; n++) begin
				if ((g == VALUE_RANGE - 1) && (n == LONG_GROUP - 1)) begin
					send_item(VALUE_W'(g), 1'b1, 1'b1, LONG_TOTAL);
				end else begin
					send_item(VALUE_W'(g), 1'b0, 1'b0, '0);
				end
			end
		end

		// The sender pauses here until every result has been transferred.
		wait_drained();

		// Random phases: no idling, sender idle, receiver stalling, then both together. The
		// first phase opens with a long receiver hold-off while items keep being offered.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
					hold_off_left = 300;
				end
				1: begin
					send_idle_pct = 54;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 54;
				end
				default: begin
					send_idle_pct = 32;
					recv_stall_pct = 32;
				end
			endcase
			sent = 0;
			while (sent < RANDOM_PER_PHASE) begin
				send_random_sequence(sent);
			end
			wait_drained();
		end

		// Nothing more is expected; allow the longest bin walk for any stray result.
		repeat (VALUE_RANGE * 3) @(posedge clk);
		if (fail_count == 0) begin
			$display("histogram_inversion_counter_top_tb: PASS");
		end else begin
			$display("histogram_inversion_counter_top_tb: FAIL");
		end
		$finish;
	end

endmodule
